// File: rtl/core/doubly_linked_list_manager_assert.svh
// ----------------------------------------------------------------------------
// doubly_linked_list_manager_assert.svh
// Assertion macros for the list manager checker, dll_checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_LIST_MANAGER_ASSERT_SVH
`define DOUBLY_LINKED_LIST_MANAGER_ASSERT_SVH

// same-cycle implication
`define DLL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DLL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/dll_pkg.sv
// ----------------------------------------------------------------------------
// dll_pkg
// Types and constants for the doubly linked list manager.
// ----------------------------------------------------------------------------
package dll_pkg;

  localparam int ACT_W = 3;
  localparam int ID_W  = 8;
  localparam int CNT_W = 9;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD_FIRST    = 3'd0,
    ACT_ADD_LAST     = 3'd1,
    ACT_ADD_AFTER    = 3'd2,
    ACT_UNLINK       = 3'd3,
    ACT_REMOVE_FIRST = 3'd4,
    ACT_REMOVE_LAST  = 3'd5,
    ACT_CLEAR        = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK,
    ST_FIX,
    ST_HOLD
  } state_e;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

endpackage

// File: rtl/core/dll_ram.sv
// ----------------------------------------------------------------------------
// dll_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dll_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/doubly_linked_list_manager.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_manager
// Each item: accept, link read + first writes, second writes; the next
//   item waits for those, set by the single write port of each link RAM,
//   and for the result load. A stalled result is held while the next
//   item is already taken in. Reset: asynchronous, empty list.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager #(
  parameter int NODES = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [dll_pkg::ACT_W-1:0] action_i,
  input  logic [dll_pkg::ID_W-1:0]  node_i,
  input  logic [dll_pkg::ID_W-1:0]  anchor_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [dll_pkg::ID_W-1:0]  removed_node_o,
  output logic                      status_o,
  output logic [dll_pkg::CNT_W-1:0] entry_total_o,
  output logic [dll_pkg::ID_W-1:0]  head_id_o,
  output logic [dll_pkg::ID_W-1:0]  tail_id_o,
  output logic                      list_empty_o
);

  import dll_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam int LW = AW + 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(NODES);

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [LW-1:0] data;
  } wr_t;

  state_e state_q, state_d;

  logic [ACT_W-1:0] act_q;
  logic [ID_W-1:0]  node_q, anchor_q;

  logic [LW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ID_W-1:0]  removed_q, removed_d;
  logic             status_q, status_d;

  wr_t fix_nx_q, fix_nx_d, fix_pv_q, fix_pv_d;
  wr_t link_nx, link_pv, nx_wr, pv_wr;

  logic [AW-1:0] rd_addr;
  logic [LW-1:0] nx_rdata, pv_rdata;
  logic [LW-1:0] item_l, anchor_l, victim;
  logic          item_ok, anchor_ok, head_ok, tail_ok, n_ok, p_ok, unl_en;
  logic          accept, load, out_free;

  logic             out_valid_q;
  logic [ID_W-1:0]  out_removed_q, out_head_q, out_tail_q;
  logic             out_status_q, out_empty_q;
  logic [CNT_W-1:0] out_total_q;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign item_l    = LW'(node_q);
  assign anchor_l  = LW'(anchor_q);
  assign item_ok   = int'(node_q) < NODES;
  assign anchor_ok = int'(anchor_q) < NODES;
  assign head_ok   = head_q < NULL_LINK;
  assign tail_ok   = tail_q < NULL_LINK;
  assign n_ok      = nx_rdata < NULL_LINK;
  assign p_ok      = pv_rdata < NULL_LINK;

  // Link read address, issued with the accept
  always_comb begin
    unique case (action_e'(action_i)) inside
      ACT_ADD_AFTER:    rd_addr = AW'(anchor_i);
      ACT_REMOVE_FIRST: rd_addr = head_q[AW-1:0];
      ACT_REMOVE_LAST:  rd_addr = tail_q[AW-1:0];
      default:          rd_addr = AW'(node_i);
    endcase
  end

  // Link stage: RAM data is back; first writes, list registers updated,
  // second writes planned for the fix stage.
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    removed_d = removed_q;
    status_d  = status_q;
    link_nx   = '0;
    link_pv   = '0;
    fix_nx_d  = '0;
    fix_pv_d  = '0;
    victim    = item_l;
    unl_en    = 1'b0;
    if (state_q == ST_LINK) begin
      removed_d = '0;
      status_d  = STATUS_OK;
      unique case (action_e'(act_q)) inside
        ACT_ADD_FIRST: begin
          if (item_ok) begin
            link_nx  = '{1'b1, item_l[AW-1:0], head_ok ? head_q : NULL_LINK};
            link_pv  = '{1'b1, item_l[AW-1:0], NULL_LINK};
            fix_pv_d = '{head_ok, head_q[AW-1:0], item_l};
            head_d   = item_l;
            if (!head_ok) begin
              tail_d = item_l;
            end
            cnt_d = cnt_q + 1'b1;
          end
        end
        ACT_ADD_LAST: begin
          if (item_ok) begin
            link_nx  = '{1'b1, item_l[AW-1:0], NULL_LINK};
            link_pv  = '{1'b1, item_l[AW-1:0], tail_ok ? tail_q : NULL_LINK};
            fix_nx_d = '{tail_ok, tail_q[AW-1:0], item_l};
            tail_d   = item_l;
            if (!tail_ok) begin
              head_d = item_l;
            end
            cnt_d = cnt_q + 1'b1;
          end
        end
        ACT_ADD_AFTER: begin
          if (item_ok && anchor_ok) begin
            link_nx  = '{1'b1, item_l[AW-1:0], nx_rdata};
            link_pv  = '{1'b1, item_l[AW-1:0], anchor_l};
            // anchor and successor writes come last so they win on aliasing
            fix_nx_d = '{1'b1, anchor_l[AW-1:0], item_l};
            fix_pv_d = '{n_ok, nx_rdata[AW-1:0], item_l};
            if (tail_q == anchor_l) begin
              tail_d = item_l;
            end
            cnt_d = cnt_q + 1'b1;
          end
        end
        ACT_UNLINK: begin
          unl_en = item_ok;
        end
        ACT_REMOVE_FIRST, ACT_REMOVE_LAST: begin
          victim = (action_e'(act_q) == ACT_REMOVE_FIRST) ? head_q : tail_q;
          if (!head_ok || !(victim < NULL_LINK)) begin
            status_d = STATUS_EMPTY;
          end else begin
            removed_d = ID_W'(victim);
            unl_en    = 1'b1;
          end
        end
        ACT_CLEAR: begin
          head_d = NULL_LINK;
          tail_d = NULL_LINK;
          cnt_d  = '0;
        end
        default: begin
        end
      endcase
      if (unl_en) begin
        link_pv = '{n_ok, nx_rdata[AW-1:0], pv_rdata};
        link_nx = '{p_ok, pv_rdata[AW-1:0], nx_rdata};
        if (head_q == victim) begin
          head_d = nx_rdata;
        end
        if (tail_q == victim) begin
          tail_d = pv_rdata;
        end
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  assign nx_wr = (state_q == ST_FIX) ? fix_nx_q : link_nx;
  assign pv_wr = (state_q == ST_FIX) ? fix_pv_q : link_pv;

  dll_ram #(
    .WIDTH (LW),
    .DEPTH (NODES)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_wr.we),
    .waddr_i (nx_wr.addr),
    .wdata_i (nx_wr.data),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (nx_rdata)
  );

  dll_ram #(
    .WIDTH (LW),
    .DEPTH (NODES)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pv_wr.we),
    .waddr_i (pv_wr.addr),
    .wdata_i (pv_wr.data),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (pv_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LINK;
        end
      end
      ST_LINK: state_d = ST_FIX;
      ST_FIX:  state_d = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD: state_d = out_free ? ST_IDLE : ST_HOLD;
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = 1'b1;
    load       = 1'b0;
    unique case (state_q)
      ST_IDLE:        in_stall_o = 1'b0;
      ST_LINK:        load       = 1'b0;
      ST_FIX, ST_HOLD: load      = out_free;
      default:        in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= NULL_LINK;
      tail_q      <= NULL_LINK;
      cnt_q       <= '0;
      fix_nx_q    <= '0;
      fix_pv_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      fix_nx_q    <= fix_nx_d;
      fix_pv_q    <= fix_pv_d;
      out_valid_q <= load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    removed_q <= removed_d;
    status_q  <= status_d;
    if (accept) begin
      act_q    <= action_i;
      node_q   <= node_i;
      anchor_q <= anchor_i;
    end
    if (load) begin
      out_removed_q <= removed_q;
      out_status_q  <= status_q;
      out_total_q   <= cnt_q;
      out_head_q    <= head_ok ? ID_W'(head_q) : '0;
      out_tail_q    <= tail_ok ? ID_W'(tail_q) : '0;
      out_empty_q   <= !head_ok;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign removed_node_o = out_removed_q;
  assign status_o       = out_status_q;
  assign entry_total_o  = out_total_q;
  assign head_id_o      = out_head_q;
  assign tail_id_o      = out_tail_q;
  assign list_empty_o   = out_empty_q;

endmodule

// File: rtl/core/dll_checker.sv
// ----------------------------------------------------------------------------
// dll_checker
// Port-level checks for the doubly linked list manager, bound to the top.
// ----------------------------------------------------------------------------
`include "doubly_linked_list_manager_assert.svh"

module dll_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [dll_pkg::ID_W-1:0]  removed_node_o,
  input logic                      status_o,
  input logic [dll_pkg::CNT_W-1:0] entry_total_o,
  input logic [dll_pkg::ID_W-1:0]  head_id_o,
  input logic [dll_pkg::ID_W-1:0]  tail_id_o,
  input logic                      list_empty_o
);

  // one item at a time: busy right after an accept
  `DLL_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input taken while an item is in flight")

  `DLL_ASSERT_IMP(a_empty_head_zero, clk_i, rst_ni, out_valid_o && list_empty_o, head_id_o == '0, "empty list reports a head id")

  `DLL_ASSERT_IMP(a_empty_remove, clk_i, rst_ni, out_valid_o && status_o, removed_node_o == '0, "failed remove reports a node")

  `DLL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(removed_node_o) && $stable(entry_total_o) && $stable(head_id_o) && $stable(tail_id_o) && $stable(status_o) && $stable(list_empty_o), "stalled result changed")

endmodule

bind doubly_linked_list_manager dll_checker u_dll_checker (.*);

// File: tb/dll_list_checker.sv
// ----------------------------------------------------------------------------
// dll_list_checker
// Watches both channels of the list manager and keeps its own copy of the
// list: the link memories, head, tail and count. Every accepted item is
// applied to that copy and the resulting view is queued. Every accepted
// result is checked against the oldest queued view.
// ----------------------------------------------------------------------------
module dll_list_checker
  import dll_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [ACT_W-1:0] action_i,
  input  logic [ID_W-1:0]  node_i,
  input  logic [ID_W-1:0]  anchor_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [ID_W-1:0]  removed_node_i,
  input  logic             status_i,
  input  logic [CNT_W-1:0] entry_total_i,
  input  logic [ID_W-1:0]  head_id_i,
  input  logic [ID_W-1:0]  tail_id_i,
  input  logic             list_empty_i,
  output int               outstanding_o,
  output int               errors_o
);

  localparam int               NODES     = 256;
  // any link with the top bit set is null
  localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(NODES);

  typedef struct packed {
    logic [ID_W-1:0]  removed;
    logic             status;
    logic [CNT_W-1:0] total;
    logic [ID_W-1:0]  head;
    logic [ID_W-1:0]  tail;
    logic             empty;
  } list_view_t;

  logic [CNT_W-1:0] next_mem [NODES];
  logic [CNT_W-1:0] prev_mem [NODES];
  logic [CNT_W-1:0] head_ptr   = NULL_LINK;
  logic [CNT_W-1:0] tail_ptr   = NULL_LINK;
  logic [CNT_W-1:0] node_count = '0;

  list_view_t expected_views [$];
  int         mismatches = 0;

  function automatic void detach(logic [CNT_W-1:0] id);
    logic [CNT_W-1:0] nx;
    logic [CNT_W-1:0] pv;
    nx = next_mem[id[ID_W-1:0]];
    pv = prev_mem[id[ID_W-1:0]];
    if (!nx[ID_W]) prev_mem[nx[ID_W-1:0]] = pv;
    if (!pv[ID_W]) next_mem[pv[ID_W-1:0]] = nx;
    if (head_ptr == id) head_ptr = nx;
    if (tail_ptr == id) tail_ptr = pv;
    node_count = node_count - 1'b1;
  endfunction

  function automatic list_view_t apply_action(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                                              logic [ID_W-1:0] anc);
    list_view_t       v;
    logic [CNT_W-1:0] link_id;
    logic [CNT_W-1:0] victim;
    logic [CNT_W-1:0] nx;
    v       = '0;
    link_id = {1'b0, id};
    case (act)
      ACT_ADD_FIRST: begin
        if (head_ptr[ID_W]) begin
          next_mem[id] = NULL_LINK;
          prev_mem[id] = NULL_LINK;
          tail_ptr     = link_id;
        end else begin
          next_mem[id] = head_ptr;
          prev_mem[id] = NULL_LINK;
          prev_mem[head_ptr[ID_W-1:0]] = link_id;
        end
        head_ptr   = link_id;
        node_count = node_count + 1'b1;
      end
      ACT_ADD_LAST: begin
        if (tail_ptr[ID_W]) begin
          next_mem[id] = NULL_LINK;
          prev_mem[id] = NULL_LINK;
          head_ptr     = link_id;
        end else begin
          next_mem[id] = NULL_LINK;
          prev_mem[id] = tail_ptr;
          next_mem[tail_ptr[ID_W-1:0]] = link_id;
        end
        tail_ptr   = link_id;
        node_count = node_count + 1'b1;
      end
      ACT_ADD_AFTER: begin
        nx           = next_mem[anc];
        next_mem[id] = nx;
        prev_mem[id] = {1'b0, anc};
        if (!nx[ID_W]) prev_mem[nx[ID_W-1:0]] = link_id;
        next_mem[anc] = link_id;
        if (tail_ptr == {1'b0, anc}) tail_ptr = link_id;
        node_count = node_count + 1'b1;
      end
      ACT_UNLINK: detach(link_id);
      ACT_REMOVE_FIRST, ACT_REMOVE_LAST: begin
        victim = (act == ACT_REMOVE_FIRST) ? head_ptr : tail_ptr;
        if (head_ptr[ID_W] || victim[ID_W]) begin
          v.status = STATUS_EMPTY;
        end else begin
          v.removed = victim[ID_W-1:0];
          detach(victim);
        end
      end
      ACT_CLEAR: begin
        head_ptr   = NULL_LINK;
        tail_ptr   = NULL_LINK;
        node_count = '0;
      end
      default: ;
    endcase
    v.total = node_count;
    v.head  = head_ptr[ID_W] ? '0 : head_ptr[ID_W-1:0];
    v.tail  = tail_ptr[ID_W] ? '0 : tail_ptr[ID_W-1:0];
    v.empty = head_ptr[ID_W];
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    list_view_t got;
    list_view_t want;
    if (!rst_ni) begin
      head_ptr   = NULL_LINK;
      tail_ptr   = NULL_LINK;
      node_count = '0;
      expected_views.delete();
      outstanding_o <= 0;
    end else begin
      // results leave before the item taken at this edge can produce one
      if (out_valid_i && !out_stall_i) begin
        got = {removed_node_i, status_i, entry_total_i, head_id_i, tail_id_i, list_empty_i};
        if (expected_views.size() == 0) begin
          if (mismatches < 10) $display("list result with nothing expected");
          mismatches++;
        end else begin
          want = expected_views.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("list mismatch (removed/status/total/head/tail/empty): %s",
                       $sformatf("exp %0d/%0b/%0d/%0d/%0d/%0b got %0d/%0b/%0d/%0d/%0d/%0b",
                                 want.removed, want.status, want.total, want.head,
                                 want.tail, want.empty, got.removed, got.status,
                                 got.total, got.head, got.tail, got.empty));
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_views.push_back(apply_action(action_i, node_i, anchor_i));
      outstanding_o <= expected_views.size();
    end
    errors_o <= mismatches;
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the list manager with directed corner items and then with episodes
// of random list actions, mostly well-formed against a shadow of the list,
// some turning into blind, corrupting actions. Sender bursts, receiver
// stalls and two long receiver hold-offs vary the timing.
// ----------------------------------------------------------------------------
module testbench;
  import dll_pkg::*;

  localparam int               NODES       = 256;
  localparam int               ITEM_TARGET = 850;
  localparam int               HOLD_CYCLES = 150;
  localparam int               IDLE_LIMIT  = 2000;
  localparam logic [ACT_W-1:0] ACT_UNUSED  = 3'd7;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic             in_stall_o;
  logic [ACT_W-1:0] action_i       = '0;
  logic [ID_W-1:0]  node_i         = '0;
  logic [ID_W-1:0]  anchor_i       = '0;
  logic             out_valid_o;
  logic             out_stall_i    = 1'b0;
  logic [ID_W-1:0]  removed_node_o;
  logic             status_o;
  logic [CNT_W-1:0] entry_total_o;
  logic [ID_W-1:0]  head_id_o;
  logic [ID_W-1:0]  tail_id_o;
  logic             list_empty_o;

  int outstanding;
  int errors;

  // shadow of the list order, valid only for well-formed steps
  logic [ID_W-1:0] order_q [$];
  bit              member  [NODES];
  // ids whose links have been written at least once
  bit              written [NODES];
  logic [ID_W-1:0] written_ids [$];

  int burst_left  = 0;
  int sent_count  = 0;
  int hold_tick   = 0;
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  doubly_linked_list_manager dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .node_i         (node_i),
    .anchor_i       (anchor_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .removed_node_o (removed_node_o),
    .status_o       (status_o),
    .entry_total_o  (entry_total_o),
    .head_id_o      (head_id_o),
    .tail_id_o      (tail_id_o),
    .list_empty_o   (list_empty_o)
  );

  dll_list_checker u_list_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .action_i       (action_i),
    .node_i         (node_i),
    .anchor_i       (anchor_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .removed_node_i (removed_node_o),
    .status_i       (status_o),
    .entry_total_i  (entry_total_o),
    .head_id_i      (head_id_o),
    .tail_id_i      (tail_id_o),
    .list_empty_i   (list_empty_o),
    .outstanding_o  (outstanding),
    .errors_o       (errors)
  );

  task automatic send_item(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                           logic [ID_W-1:0] anc);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    action_i   <= act;
    node_i     <= id;
    anchor_i   <= anc;
    in_valid_i <= 1'b1;
    if ((act == ACT_ADD_FIRST || act == ACT_ADD_LAST || act == ACT_ADD_AFTER) &&
        !written[id]) begin
      written[id] = 1'b1;
      written_ids.push_back(id);
    end
    sent_count++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic clear_list();
    send_item(ACT_CLEAR, ID_W'($urandom_range(0, NODES - 1)),
              ID_W'($urandom_range(0, NODES - 1)));
    order_q.delete();
    member = '{default: 1'b0};
  endtask

  task automatic list_step(bit noisy, int grow_pct);
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0]  id;
    logic [ID_W-1:0]  anc;
    int               idx;
    int               size;
    int               pick;
    id   = ID_W'($urandom_range(0, NODES - 1));
    anc  = ID_W'($urandom_range(0, NODES - 1));
    size = order_q.size();
    if (noisy) begin
      // blind actions; reads only ever touch links that were written
      act = ACT_W'($urandom_range(0, 7));
      if (act == ACT_UNLINK)
        id = written_ids[$urandom_range(0, written_ids.size() - 1)];
      if (act == ACT_ADD_AFTER)
        anc = written_ids[$urandom_range(0, written_ids.size() - 1)];
    end else begin
      if ($urandom_range(0, 99) < grow_pct && size < NODES) begin
        pick = $urandom_range(0, 2);
        if (pick == 0 || (pick == 2 && size == 0)) act = ACT_ADD_FIRST;
        else if (pick == 1)                        act = ACT_ADD_LAST;
        else                                       act = ACT_ADD_AFTER;
        do id = ID_W'($urandom_range(0, NODES - 1)); while (member[id]);
      end else if (size == 0) begin
        act = $urandom_range(0, 1) ? ACT_REMOVE_FIRST : ACT_REMOVE_LAST;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      act = ACT_UNLINK;
        else if (pick < 70) act = ACT_REMOVE_FIRST;
        else if (pick < 97) act = ACT_REMOVE_LAST;
        else                act = ACT_CLEAR;
      end
      case (act)
        ACT_ADD_FIRST: begin
          order_q.push_front(id);
          member[id] = 1'b1;
        end
        ACT_ADD_LAST: begin
          order_q.push_back(id);
          member[id] = 1'b1;
        end
        ACT_ADD_AFTER: begin
          idx = $urandom_range(0, size - 1);
          anc = order_q[idx];
          order_q.insert(idx + 1, id);
          member[id] = 1'b1;
        end
        ACT_UNLINK: begin
          idx = $urandom_range(0, size - 1);
          id  = order_q[idx];
          order_q.delete(idx);
          member[id] = 1'b0;
        end
        ACT_REMOVE_FIRST: if (size != 0) member[order_q.pop_front()] = 1'b0;
        ACT_REMOVE_LAST:  if (size != 0) member[order_q.pop_back()] = 1'b0;
        ACT_CLEAR: begin
          order_q.delete();
          member = '{default: 1'b0};
        end
        default: ;
      endcase
    end
    send_item(act, id, anc);
  endtask

  initial begin : stimulus
    int episode;
    int ep_len;
    int noise_from;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner items on a fresh list
    send_item(ACT_REMOVE_FIRST, 8'd0,   8'd0);
    send_item(ACT_REMOVE_LAST,  8'd255, 8'd255);
    send_item(ACT_ADD_FIRST,    8'd0,   8'd255);
    send_item(ACT_ADD_LAST,     8'd255, 8'd0);
    send_item(ACT_ADD_AFTER,    8'd128, 8'd0);
    send_item(ACT_ADD_AFTER,    8'd1,   8'd255);   // anchor is the tail
    send_item(ACT_ADD_FIRST,    8'd127, 8'd255);
    send_item(ACT_UNLINK,       8'd128, 8'd0);     // middle
    send_item(ACT_UNLINK,       8'd127, 8'd0);     // head
    send_item(ACT_UNLINK,       8'd1,   8'd0);     // tail
    send_item(ACT_UNUSED,       8'd255, 8'd255);
    send_item(ACT_REMOVE_FIRST, 8'd0,   8'd0);
    send_item(ACT_REMOVE_LAST,  8'd0,   8'd0);
    // count wraps below zero, then back to zero
    send_item(ACT_UNLINK,       8'd128, 8'd0);
    send_item(ACT_ADD_LAST,     8'd64,  8'd0);
    // double add leaves head null with a live tail
    send_item(ACT_ADD_LAST,     8'd200, 8'd0);
    send_item(ACT_ADD_LAST,     8'd64,  8'd0);
    send_item(ACT_UNLINK,       8'd64,  8'd0);
    send_item(ACT_ADD_LAST,     8'd30,  8'd0);
    send_item(ACT_REMOVE_LAST,  8'd0,   8'd0);
    send_item(ACT_ADD_FIRST,    8'd40,  8'd0);
    send_item(ACT_CLEAR,        8'd0,   8'd0);
    drain();

    // grow to a full pool while the receiver holds off
    clear_list();
    hold_tick <= hold_tick + 1;
    while (order_q.size() < NODES) list_step(1'b0, 95);
    repeat (40) list_step(1'b0, 10);
    drain();

    episode = 0;
    while (sent_count < ITEM_TARGET) begin
      clear_list();
      ep_len     = $urandom_range(4, 40);
      noise_from = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ep_len) : ep_len;
      for (int i = 0; i < ep_len; i++) list_step(i >= noise_from, 55);
      episode++;
      if (episode == 8) hold_tick <= hold_tick + 1;
      if (episode % 7 == 0) drain();
    end
    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin : receiver
    int seen;
    int span;
    int kind;
    seen = 0;
    @(posedge rst_ni);
    forever begin
      kind = $urandom_range(0, 3);
      span = $urandom_range(8, 40);
      for (int i = 0; i < span; i++) begin
        @(posedge clk_i);
        if (hold_tick != seen) begin
          seen = hold_tick;
          out_stall_i <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        case (kind)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 99) < 30);
          2:       out_stall_i <= ($urandom_range(0, 99) < 70);
          default: out_stall_i <= (i % 4 == 3);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: doubly_linked_list_manager.f
+incdir+rtl/core
rtl/core/dll_pkg.sv
rtl/core/dll_ram.sv
rtl/core/doubly_linked_list_manager.sv
rtl/core/dll_checker.sv
tb/dll_list_checker.sv
tb/testbench.sv
